>>> sv/oll_pkg.sv
package oll_pkg;

  localparam int DATA_W       = 32;
  localparam int KIND_W       = 3;
  localparam int POS_W        = 9;
  localparam int STATUS_W     = 3;
  localparam int WHERE_W      = 8;
  localparam int COUNT_W      = 9;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [KIND_W-1:0] {
    K_INS_FRONT = 3'd0,
    K_INS_BACK  = 3'd1,
    K_INS_AFTER = 3'd2,
    K_DEL_FRONT = 3'd3,
    K_DEL_BACK  = 3'd4,
    K_DEL_AT    = 3'd5,
    K_SEARCH    = 3'd6
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_RANGE     = 3'd2,
    ST_INVALID   = 3'd3,
    ST_FULL      = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_ROT  = 2'd1,
    CELL_INS  = 2'd2,
    CELL_DEL  = 2'd3
  } cell_op_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t                  op;
    logic [WHERE_W-1:0]        idx;
    logic signed [DATA_W-1:0]  val;
  } cell_ctl_t;

  typedef struct packed {
    status_t                   status;
    logic [WHERE_W-1:0]        where;
    logic signed [DATA_W-1:0]  item;
    logic [COUNT_W-1:0]        count;
  } rslt_t;

endpackage

>>> sv/oll_cell.sv
module oll_cell
  import oll_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  output logic signed [DATA_W-1:0] q
);

  localparam logic [WHERE_W-1:0] MY = WHERE_W'(INDEX);

  logic signed [DATA_W-1:0] q_next;

  always_comb begin
    q_next = q;
    case (ctl.op)
      CELL_ROT: begin
        q_next = right;
      end
      CELL_INS: begin
        if (MY == ctl.idx) begin
          q_next = ctl.val;
        end else if (MY > ctl.idx) begin
          q_next = left;
        end
      end
      CELL_DEL: begin
        // close the gap: everything at or after the hole moves toward the front
        if (MY >= ctl.idx) begin
          q_next = right;
        end
      end
      default: begin
        q_next = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

>>> sv/oll_obuf.sv
module oll_obuf
  import oll_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  rslt_t push_d,
  output logic  full,
  output logic  out_valid,
  input  logic  out_stall,
  output rslt_t out_d
);

  logic  main_v;
  logic  skid_v;
  rslt_t main_d;
  rslt_t skid_d;
  logic  pop;

  assign pop       = main_v && !out_stall;
  assign full      = main_v && skid_v;
  assign out_valid = main_v;
  assign out_d     = main_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (!main_v || pop) begin
        if (skid_v) begin
          main_v <= 1'b1;
          main_d <= skid_d;
          skid_v <= push;
          skid_d <= push_d;
        end else begin
          main_v <= push;
          main_d <= push_d;
        end
      end else if (push) begin
        // main is stalled: park the new item
        skid_v <= 1'b1;
        skid_d <= push_d;
      end
    end
  end

endmodule

>>> sv/ordered_list_engine.sv
// Ordered list of up to CAPACITY signed 32-bit values, held in a chain of
// cells (cell 0 is the front). Each request gives exactly one result with
// a status, the position touched, the value touched and the new count.
// Delete-back, delete-at and search scan the chain, which turns once around
// as a ring, one entry passing cell 0 per cycle where it is read or compared;
// then the finish state closes the gap (not for a search) and issues the
// result. One request is worked on at a time. Results go through a two-deep
// output buffer, so a new request is taken while an earlier result still
// waits downstream. Entries are not cleared at reset; only entries below the
// count are ever read.
module ordered_list_engine
  import oll_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [KIND_W-1:0]         kind,
  input  logic signed [DATA_W-1:0]  value,
  input  logic signed [POS_W-1:0]   position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STATUS_W-1:0]       status,
  output logic [WHERE_W-1:0]        where,
  output logic signed [DATA_W-1:0]  item,
  output logic [COUNT_W-1:0]        count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                   state, state_next;
  logic [CNT_W-1:0]         occ, occ_next;
  logic [IDX_W-1:0]         step, step_next;
  logic [IDX_W-1:0]         target;
  logic                     is_search;
  logic signed [DATA_W-1:0] req_val;
  logic                     found;
  logic [IDX_W-1:0]         hit_pos;
  logic signed [DATA_W-1:0] hit_val;

  logic                     accept;
  logic                     obuf_full;
  logic                     push;
  rslt_t                    res;
  rslt_t                    res_out;
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] cell_q [CAPACITY];

  logic                     empty;
  logic                     full;
  logic                     pneg;
  logic [WHERE_W-1:0]       pos_u;
  logic                     pos_in;
  logic                     do_ins;
  logic [IDX_W-1:0]         ins_idx;
  logic                     do_scan;
  logic [IDX_W-1:0]         scan_tgt;
  logic                     scan_search;
  logic                     step_in;
  logic                     scan_hit;

  assign in_stall = (state != S_IDLE) || obuf_full;
  assign accept   = in_valid && !in_stall;
  assign empty    = (occ == '0);
  assign full     = (occ == FULL_CNT);
  assign pneg     = position[POS_W-1];
  assign pos_u    = position[POS_W-2:0];
  assign pos_in   = (COUNT_W'(pos_u) < COUNT_W'(occ));
  assign step_in  = (CNT_W'(step) < occ);

  // cell chain, closed into a ring for the scan
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    oll_cell #(
      .INDEX(i)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .left ((i == 0) ? ctl.val : cell_q[(i + CAPACITY - 1) % CAPACITY]),
      .right(cell_q[(i + 1) % CAPACITY]),
      .q    (cell_q[i])
    );
  end

  always_comb begin
    state_next  = state;
    step_next   = step;
    occ_next    = occ;
    push        = 1'b0;
    do_ins      = 1'b0;
    ins_idx     = '0;
    do_scan     = 1'b0;
    scan_tgt    = '0;
    scan_search = 1'b0;
    ctl.op      = CELL_HOLD;
    ctl.idx     = '0;
    ctl.val     = value;
    res.status  = ST_OK;
    res.where   = '0;
    res.item    = '0;
    res.count   = COUNT_W'(occ);

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind)
            K_INS_FRONT: begin
              if (full) begin
                res.status = ST_FULL;
              end else begin
                do_ins = 1'b1;
              end
            end
            K_INS_BACK: begin
              if (full) begin
                res.status = ST_FULL;
              end else begin
                do_ins  = 1'b1;
                ins_idx = occ[IDX_W-1:0];
              end
            end
            K_INS_AFTER: begin
              if (empty) begin
                do_ins = 1'b1;
              end else if (full) begin
                res.status = ST_FULL;
              end else if (pneg) begin
                res.status = ST_INVALID;
              end else if (!pos_in) begin
                res.status = ST_RANGE;
              end else begin
                do_ins  = 1'b1;
                ins_idx = pos_u[IDX_W-1:0] + 1'b1;
              end
            end
            K_DEL_FRONT: begin
              if (empty) begin
                res.status = ST_EMPTY;
              end else begin
                ctl.op    = CELL_DEL;
                res.item  = cell_q[0];
                occ_next  = occ - 1'b1;
                res.count = COUNT_W'(occ_next);
              end
            end
            K_DEL_BACK: begin
              if (empty) begin
                res.status = ST_EMPTY;
              end else begin
                do_scan  = 1'b1;
                scan_tgt = IDX_W'(occ - 1'b1);
              end
            end
            K_DEL_AT: begin
              if (empty) begin
                res.status = ST_EMPTY;
              end else if (pneg) begin
                res.status = ST_INVALID;
              end else if (!pos_in) begin
                res.status = ST_RANGE;
              end else begin
                do_scan  = 1'b1;
                scan_tgt = pos_u[IDX_W-1:0];
              end
            end
            K_SEARCH: begin
              if (empty) begin
                res.status = ST_EMPTY;
              end else begin
                do_scan     = 1'b1;
                scan_search = 1'b1;
              end
            end
            default: begin
              res.status = ST_INVALID;
            end
          endcase

          if (do_ins) begin
            ctl.op    = CELL_INS;
            ctl.idx   = WHERE_W'(ins_idx);
            res.where = WHERE_W'(ins_idx);
            res.item  = value;
            occ_next  = occ + 1'b1;
            res.count = COUNT_W'(occ_next);
          end

          if (do_scan) begin
            state_next = S_SCAN;
          end else begin
            push = 1'b1;
          end
        end
      end
      S_SCAN: begin
        ctl.op    = CELL_ROT;
        step_next = step + 1'b1;
        if (step == LAST) begin
          step_next  = '0;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        push       = 1'b1;
        state_next = S_IDLE;
        if (is_search) begin
          if (found) begin
            res.where = WHERE_W'(hit_pos);
            res.item  = req_val;
          end else begin
            res.status = ST_NOT_FOUND;
          end
        end else begin
          ctl.op    = CELL_DEL;
          ctl.idx   = WHERE_W'(target);
          res.where = WHERE_W'(target);
          res.item  = hit_val;
          occ_next  = occ - 1'b1;
          res.count = COUNT_W'(occ_next);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      step  <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      step  <= step_next;
      if (do_scan) begin
        found <= 1'b0;
      end else if (state == S_SCAN && scan_hit) begin
        found <= 1'b1;
      end
    end
  end

  assign scan_hit = is_search && !found && step_in && (cell_q[0] == req_val);

  always_ff @(posedge clk) begin
    if (do_scan) begin
      target    <= scan_tgt;
      is_search <= scan_search;
      req_val   <= value;
    end
    if (state == S_SCAN) begin
      // the entry at position step sits in cell 0 now
      if (step == target) begin
        hit_val <= cell_q[0];
      end
      if (scan_hit) begin
        hit_pos <= step;
      end
    end
  end

  oll_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_d   (res),
    .full     (obuf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_d    (res_out)
  );

  assign status = res_out.status;
  assign where  = res_out.where;
  assign item   = res_out.item;
  assign count  = res_out.count;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= FULL_CNT)
    else $error("occupancy above capacity");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !obuf_full)
    else $error("result pushed into a full buffer");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (occ == $past(occ) || occ == $past(occ) + 1'b1 ||
                     occ + 1'b1 == $past(occ)))
    else $error("occupancy moved by more than one");

  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    state != S_SCAN |-> step == '0)
    else $error("scan step not parked outside a scan");
`endif

endmodule
